@@ design/olide_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olide_pkg
// Shared types and codes of the ordered list insert/delete engine: request
// and response items, operation and status codes, controller-datapath links.
// ----------------------------------------------------------------------------
package olide_pkg;

   // request operation codes
   localparam logic [2:0] OP_INS_EMPTY = 3'd0;
   localparam logic [2:0] OP_INS_HEAD  = 3'd1;
   localparam logic [2:0] OP_INS_TAIL  = 3'd2;
   localparam logic [2:0] OP_DELETE    = 3'd3;
   localparam logic [2:0] OP_VIEW      = 3'd4;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_EMPTY = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // write address select codes
   localparam logic [1:0] WR_HEAD     = 2'd0;
   localparam logic [1:0] WR_NEW_HEAD = 2'd1;
   localparam logic [1:0] WR_TAIL     = 2'd2;
   localparam logic [1:0] WR_SHIFT    = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] element;
      logic               last_result;
   } rsp_item_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       head_dec;
      logic       cnt_set1;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       pos_clr;
      logic       rd_run;
      logic       rsp_en;
      logic [2:0] rsp_status;
      logic       rsp_view;
      logic       rsp_last;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic dv;
      logic match;
      logic at_last;
   } dp_stat_type;

endpackage

@@ design/ordered_list_insert_delete_engine_unit.sv @@
`timescale 1ns / 1ps
// Inserts and empty-list errors: one result in the cycle after the transfer; busy stays low.
// Delete of an n-element list: one result when the walk ends, found or not (one walk
// from the head, one RAM read per cycle, the shift rides the walk); view: n results on
// consecutive cycles, the first after the RAM read register and the response register.
// The single RAM read port paces both. Reset empties the list at once; storage is not
// cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine_unit
// Bounded ordered list of signed 32-bit values kept as a ring in RAM, with
// insert, delete-by-value and view requests.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_engine_unit
   import olide_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_payload,
   output logic         rsp_strobe,
   output rsp_item_type rsp_payload
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // request sequencer
   olide_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_payload.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // list storage and response stage
   olide_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_payload),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_payload)
   );

endmodule

@@ design/olide_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olide_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module olide_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/olide_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olide_ctrl
// Request sequencer: decodes each request, runs the search, shift and view
// walks, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module olide_ctrl
   import olide_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_type,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_VIEW   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.pos_clr = 1'b1;
            if (start) begin
               cmd.capture  = 1'b1;
               cmd.rsp_last = 1'b1;
               case (req_type) inside
                  OP_INS_EMPTY: begin
                     cmd.rsp_en = 1'b1;
                     if (!stat.empty) begin
                        cmd.rsp_status = ST_NOT_EMPTY;
                     end else begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = WR_HEAD;
                        cmd.cnt_set1   = 1'b1;
                        cmd.rsp_status = ST_OK;
                     end
                  end
                  OP_INS_HEAD, OP_INS_TAIL: begin
                     cmd.rsp_en = 1'b1;
                     if (stat.empty) begin
                        cmd.rsp_status = ST_EMPTY;
                     end else if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = (req_type == OP_INS_HEAD) ? WR_NEW_HEAD : WR_TAIL;
                        cmd.head_dec   = (req_type == OP_INS_HEAD);
                        cmd.cnt_inc    = 1'b1;
                        cmd.rsp_status = ST_OK;
                     end
                  end
                  OP_DELETE: begin
                     if (stat.empty) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_VIEW: begin
                     if (stat.empty) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        state_in = S_VIEW;
                     end
                  end
                  default: begin
                     cmd.rsp_last = 1'b0;
                  end
               endcase
            end
         end
         // walk from the head until the first equal element
         S_SEARCH: begin
            cmd.rd_run = 1'b1;
            if (stat.match) begin
               state_in = S_SHIFT;
            end else if (stat.dv && stat.at_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         // move each later element down one place
         S_SHIFT: begin
            cmd.rd_run = 1'b1;
            if (stat.dv) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SHIFT;
            end else begin
               cmd.cnt_dec    = 1'b1;
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         // emit every element from the head
         S_VIEW: begin
            cmd.rd_run = 1'b1;
            if (stat.dv) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_view   = 1'b1;
               cmd.rsp_last   = stat.at_last;
               if (stat.at_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // a shift starts only from a found match
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && state_in == S_SHIFT) |-> stat.match)
      else $error("shift entered without a match");

   // a view walk emits only valid read data
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VIEW && cmd.rsp_en) |-> stat.dv)
      else $error("view response without read data");

   // the walk states never start without an accepted request
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> (state_ff == S_IDLE))
      else $error("walk started with no request");

endmodule

@@ design/olide_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olide_dp
// List datapath: ring storage, head slot and element count, position
// counters for the walks, and the registered response stage.
// ----------------------------------------------------------------------------
module olide_dp
   import olide_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int SLOT_W = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       val_ff;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cmp_pos_ff, cmp_pos_in;
   logic              dv_ff, dv_in;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff;
   logic [SLOT_W-1:0] new_head;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;
   logic [31:0]       wr_data;
   logic [31:0]       rd_data;

   // ring slot of a list position, head + position modulo depth
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                 input logic [CNT_W-1:0] p);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(p);
      if (s >= (CNT_W+1)'(LIST_DEPTH)) begin
         s = s - (CNT_W+1)'(LIST_DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

   // head slot one place back around the ring
   assign new_head = (head_ff == '0) ? SLOT_W'(LIST_DEPTH - 1) : head_ff - SLOT_W'(1);

   // write address and data
   always_comb begin
      wr_data = req_item.value;
      case (cmd.wr_sel)
         WR_HEAD:     wr_addr = head_ff;
         WR_NEW_HEAD: wr_addr = new_head;
         WR_TAIL:     wr_addr = slot_of(head_ff, count_ff);
         default: begin
            wr_addr = slot_of(head_ff, cmp_pos_ff - CNT_W'(1));
            wr_data = rd_data;
         end
      endcase
   end

   assign rd_addr = slot_of(head_ff, pos_ff);

   olide_ram #(
      .WIDTH (32),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // head and count updates
   always_comb begin
      head_in  = cmd.head_dec ? new_head : head_ff;
      count_in = count_ff;
      if (cmd.cnt_set1) begin
         count_in = CNT_W'(1);
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // walk position: one read per cycle while inside the list
   always_comb begin
      pos_in     = pos_ff;
      dv_in      = 1'b0;
      cmp_pos_in = cmp_pos_ff;
      if (cmd.pos_clr) begin
         pos_in = '0;
      end else if (cmd.rd_run && pos_ff < count_ff) begin
         pos_in     = pos_ff + CNT_W'(1);
         dv_in      = 1'b1;
         cmp_pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_pos_ff <= cmp_pos_in;
      if (cmd.capture) begin
         val_ff <= req_item.value;
      end
      if (cmd.rsp_en) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.element     <= cmd.rsp_view ? rd_data : '0;
         rsp_ff.last_result <= cmd.rsp_last;
      end
   end

   // status to the controller
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CNT_W'(LIST_DEPTH));
   assign stat.dv      = dv_ff;
   assign stat.match   = dv_ff && (rd_data == val_ff);
   assign stat.at_last = ((cmp_pos_ff + CNT_W'(1)) == count_ff);

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // count stays within the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("element count beyond capacity");

   // an insert never grows a full list
   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !stat.full)
      else $error("insert on full list");

   // a delete never shrinks an empty list
   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |=> (count_ff == $past(count_ff) - CNT_W'(1)) && !$past(stat.empty))
      else $error("delete count slip");

endmodule
